@@ rtl/tac_pkg.sv @@
// ----------------------------------------------------------------------------
// Tilt angle classifier package
// Shared constants, the arctangent table and the per-lane flag type.
// ----------------------------------------------------------------------------
package tac_pkg;

   localparam int ANGLE_FRACTION_BITS = 8;
   localparam int ANGLE_WIDTH         = 16;
   localparam int THRESH_WIDTH        = 15;
   localparam int TABLE_FRAC          = 24;
   localparam int CORDIC_STEPS        = 24;
   localparam int ANGLE_ACC_WIDTH     = 32;
   localparam int ROUND_SHIFT         = TABLE_FRAC - ANGLE_FRACTION_BITS;

   localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = THRESH_WIDTH'(2560);
   localparam logic signed [ANGLE_WIDTH-1:0] ANGLE_LIMIT =
      ANGLE_WIDTH'(90 << ANGLE_FRACTION_BITS);

   // Arctangent of 2^-i in degrees, 24 fraction bits.
   localparam logic signed [ANGLE_ACC_WIDTH-1:0] ATAN_TABLE [0:CORDIC_STEPS-1] = '{
      32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
      32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
      32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
      32'sd234683,    32'sd117342,    32'sd58671,     32'sd29335,
      32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
      32'sd917,       32'sd458,       32'sd229,       32'sd115
   };

   typedef struct packed {
      logic sum_zero;
      logic num_zero;
      logic num_neg;
   } tac_flags_type;

endpackage

@@ rtl/tac_tilt_lane.sv @@
// ----------------------------------------------------------------------------
// Tilt lane
// Pipelined square root followed by a pipelined vectoring CORDIC and rounding.
// ----------------------------------------------------------------------------
module tac_tilt_lane #(
   parameter int SAMPLE_WIDTH = 16,
   localparam int GUARD_BITS = (SAMPLE_WIDTH < 24) ? 24 - SAMPLE_WIDTH : 0,
   localparam int NUM_WIDTH  = SAMPLE_WIDTH + GUARD_BITS,
   localparam int RAD_WIDTH  = 2 * NUM_WIDTH
) (
   input  logic                                clock,
   input  logic                                enable,
   input  tac_pkg::tac_flags_type              flags,
   input  logic [NUM_WIDTH-1:0]                num_mag,
   input  logic [RAD_WIDTH-1:0]                radicand,
   output logic signed [tac_pkg::ANGLE_WIDTH-1:0] angle
);
   import tac_pkg::*;

   localparam int XW = NUM_WIDTH + 3;
   localparam int CS = CORDIC_STEPS;

   // Square root: one result bit per stage.
   logic [RAD_WIDTH-1:0] rem_ff  [0:NUM_WIDTH-2];
   logic [NUM_WIDTH-1:0] root_ff [0:NUM_WIDTH-1];
   logic [NUM_WIDTH-1:0] num_ff  [0:NUM_WIDTH-1];
   tac_flags_type        sflg_ff [0:NUM_WIDTH-1];

   for (genvar s = 0; s < NUM_WIDTH; s++) begin : g_sqrt
      localparam int K = NUM_WIDTH - 1 - s;
      logic [RAD_WIDTH-1:0] rem_src;
      logic [NUM_WIDTH-1:0] root_src;
      logic [NUM_WIDTH-1:0] num_src;
      tac_flags_type        flg_src;
      logic [RAD_WIDTH-1:0] trial;
      logic                 take;

      if (s == 0) begin : g_first
         assign rem_src  = radicand;
         assign root_src = '0;
         assign num_src  = num_mag;
         assign flg_src  = flags;
      end else begin : g_next
         assign rem_src  = rem_ff[s-1];
         assign root_src = root_ff[s-1];
         assign num_src  = num_ff[s-1];
         assign flg_src  = sflg_ff[s-1];
      end

      always_comb begin
         trial = (RAD_WIDTH'(root_src) << (K + 1)) | (RAD_WIDTH'(1) << (2 * K));
         take  = rem_src >= trial;
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            root_ff[s] <= take ? (root_src | (NUM_WIDTH'(1) << K)) : root_src;
            num_ff[s]  <= num_src;
            sflg_ff[s] <= flg_src;
         end
      end

      if (s < NUM_WIDTH - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[s] <= take ? (rem_src - trial) : rem_src;
            end
         end
      end
   end

   // Vectoring CORDIC: one micro-rotation per stage.
   logic signed [XW-1:0]              x_ff   [0:CS-2];
   logic signed [XW-1:0]              y_ff   [0:CS-2];
   logic signed [ANGLE_ACC_WIDTH-1:0] z_ff   [0:CS-1];
   tac_flags_type                     cflg_ff[0:CS-1];

   for (genvar c = 0; c < CS; c++) begin : g_cordic
      logic signed [XW-1:0]              x_src;
      logic signed [XW-1:0]              y_src;
      logic signed [ANGLE_ACC_WIDTH-1:0] z_src;
      tac_flags_type                     flg_src;
      logic signed [XW-1:0]              x_in;
      logic signed [XW-1:0]              y_in;
      logic signed [ANGLE_ACC_WIDTH-1:0] z_in;

      if (c == 0) begin : g_first
         assign x_src   = XW'(root_ff[NUM_WIDTH-1]);
         assign y_src   = XW'(num_ff[NUM_WIDTH-1]);
         assign z_src   = '0;
         assign flg_src = sflg_ff[NUM_WIDTH-1];
      end else begin : g_next
         assign x_src   = x_ff[c-1];
         assign y_src   = y_ff[c-1];
         assign z_src   = z_ff[c-1];
         assign flg_src = cflg_ff[c-1];
      end

      always_comb begin
         x_in = x_src;
         y_in = y_src;
         z_in = z_src;
         if (y_src > 0) begin
            x_in = x_src + (y_src >>> c);
            y_in = y_src - (x_src >>> c);
            z_in = z_src + ATAN_TABLE[c];
         end else if (y_src < 0) begin
            x_in = x_src - (y_src >>> c);
            y_in = y_src + (x_src >>> c);
            z_in = z_src - ATAN_TABLE[c];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            z_ff[c]    <= z_in;
            cflg_ff[c] <= flg_src;
         end
      end

      if (c < CS - 1) begin : g_xy
         always_ff @(posedge clock) begin
            if (enable) begin
               x_ff[c] <= x_in;
               y_ff[c] <= y_in;
            end
         end
      end
   end

   // Rounding, limiting and sign.
   logic signed [ANGLE_ACC_WIDTH-1:0] z_round;
   logic signed [ANGLE_WIDTH-1:0]     mag_in;
   logic signed [ANGLE_WIDTH-1:0]     angle_in;
   logic signed [ANGLE_WIDTH-1:0]     angle_ff;
   tac_flags_type                     fin_flg;

   always_comb begin
      fin_flg = cflg_ff[CS-1];
      z_round = z_ff[CS-1] + (ANGLE_ACC_WIDTH'(1) <<< (ROUND_SHIFT - 1));
      mag_in  = ANGLE_WIDTH'(z_round >>> ROUND_SHIFT);
      if (mag_in < 0) begin
         mag_in = '0;
      end else if (mag_in > ANGLE_LIMIT) begin
         mag_in = ANGLE_LIMIT;
      end
      if (fin_flg.num_zero) begin
         angle_in = '0;
      end else if (fin_flg.sum_zero) begin
         angle_in = fin_flg.num_neg ? -ANGLE_LIMIT : ANGLE_LIMIT;
      end else begin
         angle_in = fin_flg.num_neg ? -mag_in : mag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         angle_ff <= angle_in;
      end
   end

   assign angle = angle_ff;

endmodule

@@ rtl/tilt_angle_classifier_unit.sv @@
// ----------------------------------------------------------------------------
// Tilt angle classifier
// Roll and pitch from a three-axis acceleration sample, with tilt indicators.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Contents
//   req_      in         req_valid/req_ready    accel_x, accel_y, accel_z
//   rsp_      out        rsp_valid/rsp_ready    angles and four indicators
//   csr_      in         csr_valid/csr_ready    tilt limit
//
// One transaction is accepted in every cycle while req_ready is high. The
// pipeline is a squares stage, a sums stage, one per root bit in the square
// root, 24 CORDIC stages, one rounding stage and the output register.
// Reset clears the valid bits and reloads the threshold with 10 degrees.
// When the output holds a transaction that is not taken, the whole pipeline
// freezes, so nothing is lost or repeated; req_ready is low only then.
//
module tilt_angle_classifier_unit #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]         req_accel_x,
   input  logic signed [SAMPLE_WIDTH-1:0]         req_accel_y,
   input  logic signed [SAMPLE_WIDTH-1:0]         req_accel_z,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [tac_pkg::ANGLE_WIDTH-1:0] rsp_roll_angle,
   output logic signed [tac_pkg::ANGLE_WIDTH-1:0] rsp_pitch_angle,
   output logic                                   rsp_roll_right,
   output logic                                   rsp_roll_left,
   output logic                                   rsp_pitch_forward,
   output logic                                   rsp_pitch_back,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [tac_pkg::THRESH_WIDTH-1:0]       csr_tilt_limit
);
   import tac_pkg::*;

   localparam int GUARD_BITS = (SAMPLE_WIDTH < 24) ? 24 - SAMPLE_WIDTH : 0;
   localparam int NUM_WIDTH  = SAMPLE_WIDTH + GUARD_BITS;
   localparam int RAD_WIDTH  = 2 * NUM_WIDTH;
   localparam int SQ_WIDTH   = 2 * SAMPLE_WIDTH;
   // Squares, sums, lane (root bits, CORDIC steps, rounding), output.
   localparam int LATENCY    = 2 + NUM_WIDTH + CORDIC_STEPS + 1 + 1;

   // The whole pipeline moves together whenever the output can move.
   logic advance;
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;

   // Threshold register.
   logic [THRESH_WIDTH-1:0] thresh_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else if (csr_valid && csr_ready) begin
         thresh_ff <= csr_tilt_limit;
      end
   end

   // Valid bits travel alongside the data.
   logic vld_ff [0:LATENCY-1];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LATENCY; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < LATENCY; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   // First stage: the three squares, with the raw samples kept for the
   // numerators.
   logic [SQ_WIDTH-1:0]            sq_x_ff, sq_y_ff, sq_z_ff;
   logic signed [SAMPLE_WIDTH-1:0] ax_ff, ay_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         sq_x_ff <= SQ_WIDTH'(req_accel_x * req_accel_x);
         sq_y_ff <= SQ_WIDTH'(req_accel_y * req_accel_y);
         sq_z_ff <= SQ_WIDTH'(req_accel_z * req_accel_z);
         ax_ff   <= req_accel_x;
         ay_ff   <= req_accel_y;
      end
   end

   // Second stage: the sums under each root, scaled by the guard bits, and
   // the numerator magnitudes with their flags. Each square is at most
   // 2^(2*SAMPLE_WIDTH-2), so the sum cannot carry out.
   logic [SQ_WIDTH-1:0]     sum_roll_in, sum_pitch_in;
   logic [SAMPLE_WIDTH-1:0] mag_x_in, mag_y_in;
   logic [RAD_WIDTH-1:0]    rad_roll_ff, rad_pitch_ff;
   logic [NUM_WIDTH-1:0]    num_roll_ff, num_pitch_ff;
   tac_flags_type           flg_roll_ff, flg_pitch_ff;

   always_comb begin
      sum_roll_in  = sq_y_ff + sq_z_ff;
      sum_pitch_in = sq_x_ff + sq_z_ff;
      mag_x_in     = ax_ff[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-ax_ff) : ax_ff;
      mag_y_in     = ay_ff[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-ay_ff) : ay_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rad_roll_ff           <= RAD_WIDTH'(sum_roll_in) << (2 * GUARD_BITS);
         rad_pitch_ff          <= RAD_WIDTH'(sum_pitch_in) << (2 * GUARD_BITS);
         num_roll_ff           <= NUM_WIDTH'(mag_x_in) << GUARD_BITS;
         num_pitch_ff          <= NUM_WIDTH'(mag_y_in) << GUARD_BITS;
         flg_roll_ff.sum_zero  <= sum_roll_in == '0;
         flg_roll_ff.num_zero  <= ax_ff == '0;
         flg_roll_ff.num_neg   <= ax_ff[SAMPLE_WIDTH-1];
         flg_pitch_ff.sum_zero <= sum_pitch_in == '0;
         flg_pitch_ff.num_zero <= ay_ff == '0;
         flg_pitch_ff.num_neg  <= ay_ff[SAMPLE_WIDTH-1];
      end
   end

   // The two angle lanes run in lock step.
   logic signed [ANGLE_WIDTH-1:0] roll_lane, pitch_lane;

   tac_tilt_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_roll_lane (
      .clock    (clock),
      .enable   (advance),
      .flags    (flg_roll_ff),
      .num_mag  (num_roll_ff),
      .radicand (rad_roll_ff),
      .angle    (roll_lane)
   );

   tac_tilt_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_pitch_lane (
      .clock    (clock),
      .enable   (advance),
      .flags    (flg_pitch_ff),
      .num_mag  (num_pitch_ff),
      .radicand (rad_pitch_ff),
      .angle    (pitch_lane)
   );

   // Output register: the angles and their threshold comparisons. The
   // comparisons are made one bit wider so that the negated threshold fits.
   logic signed [ANGLE_WIDTH:0] roll_wide, pitch_wide, thr_pos, thr_neg;
   logic signed [ANGLE_WIDTH-1:0] roll_ff, pitch_ff;
   logic roll_right_ff, roll_left_ff, pitch_forward_ff, pitch_back_ff;

   always_comb begin
      roll_wide  = {roll_lane[ANGLE_WIDTH-1], roll_lane};
      pitch_wide = {pitch_lane[ANGLE_WIDTH-1], pitch_lane};
      thr_pos    = $signed((ANGLE_WIDTH + 1)'(thresh_ff));
      thr_neg    = -thr_pos;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         roll_ff          <= roll_lane;
         pitch_ff         <= pitch_lane;
         roll_right_ff    <= roll_wide > thr_pos;
         roll_left_ff     <= roll_wide < thr_neg;
         pitch_forward_ff <= pitch_wide > thr_pos;
         pitch_back_ff    <= pitch_wide < thr_neg;
      end
   end

   assign rsp_valid         = vld_ff[LATENCY-1];
   assign rsp_roll_angle    = roll_ff;
   assign rsp_pitch_angle   = pitch_ff;
   assign rsp_roll_right    = roll_right_ff;
   assign rsp_roll_left     = roll_left_ff;
   assign rsp_pitch_forward = pitch_forward_ff;
   assign rsp_pitch_back    = pitch_back_ff;

`ifndef SYNTH
   // Nothing leaves the pipeline straight after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Angles never pass ninety degrees either way.
   a_roll_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_roll_angle <= ANGLE_LIMIT && rsp_roll_angle >= -ANGLE_LIMIT))
      else $error("roll angle out of range");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pitch_angle <= ANGLE_LIMIT && rsp_pitch_angle >= -ANGLE_LIMIT))
      else $error("pitch angle out of range");

   // An indicator agrees with the sign of its angle.
   a_roll_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_roll_right || rsp_roll_angle > 0)
                 && (!rsp_roll_left || rsp_roll_angle < 0))
      else $error("roll indicator disagrees with roll angle");

   a_pitch_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_pitch_forward || rsp_pitch_angle > 0)
                 && (!rsp_pitch_back || rsp_pitch_angle < 0))
      else $error("pitch indicator disagrees with pitch angle");
`endif

endmodule
